>>> sv/assert_macros.svh
// Assertion macros used by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define TLC_ASSERT_IMPLY(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define TLC_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/tlc_pkg.sv
// Shared types, codes and helpers for the TTL LRU cache.
package tlc_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 32;
    localparam int CAP_W       = 7;
    localparam int TTL_W       = 17;
    localparam int TTL_MAX     = 86400;

    typedef enum logic [1:0] {
        ACT_GET   = 2'd0,
        ACT_PUT   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_TICK  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_ABSENT   = 3'd1,
        ST_EXPIRED  = 3'd2,
        ST_UPDATED  = 3'd3,
        ST_INSERTED = 3'd4,
        ST_EVICTED  = 3'd5,
        ST_CLEARED  = 3'd6,
        ST_TICKED   = 3'd7
    } status_t;

    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_TTL      = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        M_PROMOTE,
        M_DROP,
        M_INSERT
    } upd_mode_t;

    typedef struct packed {
        upd_mode_t          mode;
        logic               wr_payload;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [TIME_W-1:0]  deadline;
    } upd_ctrl_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

>>> sv/ttl_lru_cache.sv
// Fully associative key/data cache with LRU replacement and per-entry time to live.
// Get and put make one pass over the entry RAM to find the key, the least recent entry
// and a free slot, then a second read-modify-write pass that fixes recency ranks. The
// input opens in the same cycle that the result is presented. A get that does not find
// the key skips the second pass. Clear and tick skip both passes. A stalled result holds
// the block and its input. The entry RAM takes one read and one write per cycle.
// Configuration writes are always taken; valid bits live in flip-flops so reset and
// clear act at once.
`include "assert_macros.svh"

module ttl_lru_cache #(
    parameter int ENTRIES = tlc_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [tlc_pkg::TTL_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  action,
    input  logic [tlc_pkg::KEY_W-1:0]   lookup_key,
    input  logic [tlc_pkg::DATA_W-1:0]  write_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  status,
    output logic [tlc_pkg::DATA_W-1:0]  read_value,
    output logic [6:0]                  entry_count,
    output logic [tlc_pkg::CNT_W-1:0]   hit_count,
    output logic [tlc_pkg::CNT_W-1:0]   miss_count,
    output logic [tlc_pkg::CNT_W-1:0]   expiration_count,
    output logic [tlc_pkg::CNT_W-1:0]   eviction_count,
    output logic [tlc_pkg::CNT_W-1:0]   invalidation_count
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int WW = 3 * 32 + AW;

    tlc_pkg::state_t state_reg, state_next;

    logic [ENTRIES-1:0]          valid_reg;
    logic [CW-1:0]               occ_reg;
    logic [tlc_pkg::TIME_W-1:0]  time_reg;
    logic [tlc_pkg::CNT_W-1:0]   hits_reg, misses_reg, expir_reg, evict_reg, inval_reg;
    logic [tlc_pkg::CAP_W-1:0]   cap_reg;
    logic [tlc_pkg::TTL_W-1:0]   ttl_reg;

    logic [CW-1:0]               cnt_reg;
    logic                        pv_reg;
    logic [AW-1:0]               pidx_reg;

    tlc_pkg::action_t            act_reg;
    logic [tlc_pkg::KEY_W-1:0]   key_reg;
    logic [tlc_pkg::DATA_W-1:0]  val_reg;

    logic                        found_reg, free_found_reg;
    logic [AW-1:0]               slot_reg, lru_reg, free_reg;
    logic [AW-1:0]               slot_rank_reg;
    logic [31:0]                 slot_dl_reg;
    logic [31:0]                 slot_data_reg;

    tlc_pkg::upd_mode_t          mode_reg;
    logic                        wr_payload_reg;
    logic [AW-1:0]               target_reg, ref_rank_reg;
    logic [31:0]                 deadline_reg;

    tlc_pkg::status_t            res_status_reg;
    logic [31:0]                 res_value_reg;

    logic                        out_valid_reg;
    logic [2:0]                  status_reg;
    logic [31:0]                 read_value_reg;
    logic [6:0]                  entry_count_reg;
    logic [31:0]                 hit_out_reg, miss_out_reg, expir_out_reg;
    logic [31:0]                 evict_out_reg, inval_out_reg;

    logic [WW-1:0]               rd_word, wr_word;
    logic                        upd_we, ram_we;
    logic                        in_xfer, out_free, cnt_live;
    logic                        ent_valid;
    logic [31:0]                 rd_key, rd_dl;
    logic [AW-1:0]               rd_rank;
    logic [CW-1:0]               cap_eff;
    logic [31:0]                 ttl_eff, deadline_new, age;
    logic                        expired, need_evict;
    logic [AW-1:0]               ins_slot;
    tlc_pkg::upd_ctrl_t          upd_ctrl;

    tlc_pkg::status_t            dec_status;
    logic [31:0]                 dec_value;
    tlc_pkg::upd_mode_t          dec_mode;
    logic                        dec_payload;
    logic [AW-1:0]               dec_target;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != tlc_pkg::S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cnt_live  = (cnt_reg < CW'(ENTRIES));

    assign ent_valid = valid_reg[pidx_reg];
    assign rd_key    = rd_word[WW-1 -: 32];
    assign rd_dl     = rd_word[AW +: 32];
    assign rd_rank   = rd_word[AW-1:0];

    // Clamp configuration into its legal range.
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CW'(1);
        else if (32'(cap_reg) > 32'(ENTRIES))
            cap_eff = CW'(ENTRIES);
        else
            cap_eff = CW'(cap_reg);
        if (ttl_reg == '0)
            ttl_eff = 32'd1;
        else if (32'(ttl_reg) > 32'(tlc_pkg::TTL_MAX))
            ttl_eff = 32'(tlc_pkg::TTL_MAX);
        else
            ttl_eff = 32'(ttl_reg);
    end

    assign deadline_new = time_reg + ttl_eff;
    assign age          = time_reg - slot_dl_reg;
    assign expired      = !age[31];
    assign need_evict   = (occ_reg >= cap_eff);

    // Lowest free index after the eviction.
    always_comb
    begin
        if (!need_evict)
            ins_slot = free_reg;
        else if (free_found_reg && free_reg < lru_reg)
            ins_slot = free_reg;
        else
            ins_slot = lru_reg;
    end

    // Result and update pass settings chosen at the decide step.
    always_comb
    begin
        dec_status  = tlc_pkg::ST_TICKED;
        dec_value   = '0;
        dec_mode    = tlc_pkg::M_PROMOTE;
        dec_payload = 1'b0;
        dec_target  = slot_reg;
        unique case (act_reg)
            tlc_pkg::ACT_GET:
            begin
                if (!found_reg)
                    dec_status = tlc_pkg::ST_ABSENT;
                else if (expired)
                begin
                    dec_status = tlc_pkg::ST_EXPIRED;
                    dec_mode   = tlc_pkg::M_DROP;
                end
                else
                begin
                    dec_status = tlc_pkg::ST_HIT;
                    dec_value  = slot_data_reg;
                end
            end
            tlc_pkg::ACT_PUT:
            begin
                if (found_reg)
                begin
                    dec_status  = tlc_pkg::ST_UPDATED;
                    dec_payload = 1'b1;
                end
                else
                begin
                    dec_status = need_evict ? tlc_pkg::ST_EVICTED : tlc_pkg::ST_INSERTED;
                    dec_mode   = tlc_pkg::M_INSERT;
                    dec_target = ins_slot;
                end
            end
            tlc_pkg::ACT_CLEAR:
            begin
                dec_status = tlc_pkg::ST_CLEARED;
            end
            tlc_pkg::ACT_TICK:
            begin
                dec_status = tlc_pkg::ST_TICKED;
            end
            default:
            begin
                dec_status = tlc_pkg::ST_TICKED;
            end
        endcase
    end

    assign upd_ctrl = '{mode: mode_reg, wr_payload: wr_payload_reg, key: key_reg,
                        data: val_reg, deadline: deadline_reg};

    assign ram_we = (state_reg == tlc_pkg::S_UPDATE) && pv_reg && upd_we;

    tlc_ram #(
        .WIDTH (WW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pidx_reg),
        .wdata (wr_word),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rd_word)
    );

    tlc_rank_upd #(
        .AW (AW)
    ) u_rank_upd (
        .ent_valid (ent_valid),
        .idx       (pidx_reg),
        .target    (target_reg),
        .ref_rank  (ref_rank_reg),
        .ctrl      (upd_ctrl),
        .rd_word   (rd_word),
        .wr_word   (wr_word),
        .we        (upd_we)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlc_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (action == tlc_pkg::ACT_GET || action == tlc_pkg::ACT_PUT)
                        state_next = tlc_pkg::S_SCAN;
                    else
                        state_next = tlc_pkg::S_DECIDE;
                end
            end
            tlc_pkg::S_SCAN:
            begin
                if (!cnt_live)
                    state_next = tlc_pkg::S_DECIDE;
            end
            tlc_pkg::S_DECIDE:
            begin
                if (act_reg == tlc_pkg::ACT_PUT || (act_reg == tlc_pkg::ACT_GET && found_reg))
                    state_next = tlc_pkg::S_UPDATE;
                else
                    state_next = tlc_pkg::S_RESP;
            end
            tlc_pkg::S_UPDATE:
            begin
                if (!cnt_live)
                    state_next = tlc_pkg::S_RESP;
            end
            tlc_pkg::S_RESP:
            begin
                if (out_free)
                    state_next = tlc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tlc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= tlc_pkg::CAP_W'(64);
            ttl_reg <= tlc_pkg::TTL_W'(60);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tlc_pkg::reg_index_t'(cfg_index))
                tlc_pkg::REG_CAPACITY: cap_reg <= cfg_data[tlc_pkg::CAP_W-1:0];
                tlc_pkg::REG_TTL:      ttl_reg <= cfg_data;
                default:               cap_reg <= cap_reg;
            endcase
        end
    end

    // Control state: valid bits, occupancy, time, totals, pass counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            occ_reg        <= '0;
            time_reg       <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            expir_reg      <= '0;
            evict_reg      <= '0;
            inval_reg      <= '0;
            cnt_reg        <= '0;
            pv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == tlc_pkg::S_RESP && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                tlc_pkg::S_IDLE:
                begin
                    cnt_reg        <= '0;
                    pv_reg         <= 1'b0;
                    found_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                end
                tlc_pkg::S_SCAN, tlc_pkg::S_UPDATE:
                begin
                    pv_reg <= cnt_live;
                    if (cnt_live)
                        cnt_reg <= cnt_reg + 1'b1;
                    if (state_reg == tlc_pkg::S_SCAN && pv_reg)
                    begin
                        if (ent_valid && rd_key == key_reg && !found_reg)
                            found_reg <= 1'b1;
                        if (!ent_valid)
                            free_found_reg <= 1'b1;
                    end
                end
                tlc_pkg::S_DECIDE:
                begin
                    cnt_reg <= '0;
                    pv_reg  <= 1'b0;
                    unique case (act_reg)
                        tlc_pkg::ACT_GET:
                        begin
                            if (!found_reg)
                                misses_reg <= tlc_pkg::sat_add(misses_reg, 32'd1);
                            else if (expired)
                            begin
                                valid_reg[slot_reg] <= 1'b0;
                                occ_reg             <= occ_reg - 1'b1;
                                misses_reg <= tlc_pkg::sat_add(misses_reg, 32'd1);
                                expir_reg  <= tlc_pkg::sat_add(expir_reg, 32'd1);
                            end
                            else
                                hits_reg <= tlc_pkg::sat_add(hits_reg, 32'd1);
                        end
                        tlc_pkg::ACT_PUT:
                        begin
                            if (!found_reg)
                            begin
                                // Evicted slot is reused when it is the lowest free one.
                                if (need_evict)
                                begin
                                    if (lru_reg != ins_slot)
                                        valid_reg[lru_reg] <= 1'b0;
                                    evict_reg <= tlc_pkg::sat_add(evict_reg, 32'd1);
                                    occ_reg   <= occ_reg;
                                end
                                else
                                    occ_reg <= occ_reg + 1'b1;
                                valid_reg[ins_slot] <= 1'b1;
                            end
                        end
                        tlc_pkg::ACT_CLEAR:
                        begin
                            inval_reg <= tlc_pkg::sat_add(inval_reg, 32'(occ_reg));
                            valid_reg <= '0;
                            occ_reg   <= '0;
                        end
                        tlc_pkg::ACT_TICK:
                        begin
                            time_reg <= time_reg + 1'b1;
                        end
                        default:
                        begin
                            time_reg <= time_reg;
                        end
                    endcase
                end
                tlc_pkg::S_RESP:
                begin
                    pv_reg <= 1'b0;
                end
                default:
                begin
                    pv_reg <= 1'b0;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg <= tlc_pkg::action_t'(action);
            key_reg <= lookup_key;
            val_reg <= write_value;
        end
        if (state_reg == tlc_pkg::S_SCAN && pv_reg)
        begin
            if (ent_valid && rd_key == key_reg && !found_reg)
            begin
                slot_reg      <= pidx_reg;
                slot_rank_reg <= rd_rank;
                slot_dl_reg   <= rd_dl;
                slot_data_reg <= rd_word[AW+32 +: 32];
            end
            if (ent_valid && CW'(rd_rank) + 1'b1 == occ_reg)
                lru_reg <= pidx_reg;
            if (!ent_valid && !free_found_reg)
                free_reg <= pidx_reg;
        end
        if (state_reg == tlc_pkg::S_SCAN || state_reg == tlc_pkg::S_UPDATE)
        begin
            pidx_reg <= cnt_reg[AW-1:0];
        end
        if (state_reg == tlc_pkg::S_DECIDE)
        begin
            deadline_reg   <= deadline_new;
            res_value_reg  <= dec_value;
            wr_payload_reg <= dec_payload;
            target_reg     <= dec_target;
            ref_rank_reg   <= slot_rank_reg;
            mode_reg       <= dec_mode;
            res_status_reg <= dec_status;
        end
        if (state_reg == tlc_pkg::S_RESP && out_free)
        begin
            status_reg      <= res_status_reg;
            read_value_reg  <= res_value_reg;
            entry_count_reg <= 7'(occ_reg);
            hit_out_reg     <= hits_reg;
            miss_out_reg    <= misses_reg;
            expir_out_reg   <= expir_reg;
            evict_out_reg   <= evict_reg;
            inval_out_reg   <= inval_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign read_value         = read_value_reg;
    assign entry_count        = entry_count_reg;
    assign hit_count          = hit_out_reg;
    assign miss_count         = miss_out_reg;
    assign expiration_count   = expir_out_reg;
    assign eviction_count     = evict_out_reg;
    assign invalidation_count = inval_out_reg;

    `TLC_ASSERT_IMPLY(a_occ_matches_valid, clk, rst_n, 1'b1,
        $countones(valid_reg) == 32'(occ_reg))
    `TLC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_xfer, in_stall)
    `TLC_ASSERT_NEXT(a_resp_drives_out, clk, rst_n,
        state_reg == tlc_pkg::S_RESP && out_free, out_valid && !in_stall)

endmodule

>>> sv/tlc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/tlc_rank_upd.sv
// Rewrite of one stored entry during the recency pass.
module tlc_rank_upd #(
    parameter int AW = 6
) (
    input  logic                 ent_valid,
    input  logic [AW-1:0]        idx,
    input  logic [AW-1:0]        target,
    input  logic [AW-1:0]        ref_rank,
    input  tlc_pkg::upd_ctrl_t   ctrl,
    input  logic [3*32+AW-1:0]   rd_word,
    output logic [3*32+AW-1:0]   wr_word,
    output logic                 we
);

    logic [AW-1:0] rank;

    assign rank = rd_word[AW-1:0];

    always_comb
    begin
        wr_word = rd_word;
        we      = 1'b0;
        unique case (ctrl.mode)
            tlc_pkg::M_PROMOTE:
            begin
                if (idx == target)
                begin
                    we = 1'b1;
                    wr_word[AW-1:0] = '0;
                    if (ctrl.wr_payload)
                    begin
                        wr_word[AW+32 +: 32] = ctrl.data;
                        wr_word[AW +: 32]    = ctrl.deadline;
                    end
                end
                else if (ent_valid && rank < ref_rank)
                begin
                    we = 1'b1;
                    wr_word[AW-1:0] = rank + 1'b1;
                end
            end
            tlc_pkg::M_DROP:
            begin
                if (ent_valid && rank > ref_rank)
                begin
                    we = 1'b1;
                    wr_word[AW-1:0] = rank - 1'b1;
                end
            end
            tlc_pkg::M_INSERT:
            begin
                if (idx == target)
                begin
                    we = 1'b1;
                    wr_word = {ctrl.key, ctrl.data, ctrl.deadline, {AW{1'b0}}};
                end
                else if (ent_valid)
                begin
                    we = 1'b1;
                    wr_word[AW-1:0] = rank + 1'b1;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

endmodule

>>> sim/ttl_lru_cache_tb.sv
// Testbench for ttl_lru_cache: directed and random get/put/clear/tick traffic checked by a scoreboard.
`timescale 1ns / 1ps

module ttl_lru_cache_tb;

    typedef struct {
        tlc_pkg::status_t status;
        logic [31:0] read_value;
        logic [6:0]  entry_count;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] expires;
        logic [31:0] evicts;
        logic [31:0] invals;
    } cache_reply_t;

    class cache_scoreboard;
        bit          ent_valid [64];
        logic [31:0] ent_key [64];
        logic [31:0] ent_data [64];
        logic [31:0] ent_deadline [64];
        int unsigned ent_rank [64];
        int unsigned occ;
        logic [31:0] now;
        logic [31:0] hits, misses, expires, evicts, invals;
        int unsigned cap_reg;
        int unsigned ttl_reg;
        cache_reply_t replies_q[$];
        int errors;

        function new();
            foreach (ent_valid[i]) ent_valid[i] = 0;
            occ = 0;
            now = 0;
            hits = 0; misses = 0; expires = 0; evicts = 0; invals = 0;
            cap_reg = 64;
            ttl_reg = 60;
            errors = 0;
        endfunction

        function logic [31:0] sat_bump(logic [31:0] a, int unsigned b);
            logic [32:0] s;
            s = {1'b0, a} + 33'(b);
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void write_reg(tlc_pkg::reg_index_t idx, logic [tlc_pkg::TTL_W-1:0] val);
            if (idx == tlc_pkg::REG_CAPACITY)
                cap_reg = val & 17'h7F;
            else
                ttl_reg = val;
        endfunction

        function int find_slot(logic [31:0] k);
            for (int i = 0; i < 64; i++)
                if (ent_valid[i] && ent_key[i] == k)
                    return i;
            return -1;
        endfunction

        function void promote(int slot);
            int unsigned r;
            r = ent_rank[slot];
            for (int i = 0; i < 64; i++)
                if (ent_valid[i] && ent_rank[i] < r)
                    ent_rank[i]++;
            ent_rank[slot] = 0;
        endfunction

        function void drop(int slot);
            int unsigned r;
            r = ent_rank[slot];
            ent_valid[slot] = 0;
            for (int i = 0; i < 64; i++)
                if (ent_valid[i] && ent_rank[i] > r)
                    ent_rank[i]--;
            if (occ > 0)
                occ--;
        endfunction

        function void note_input(tlc_pkg::action_t act, logic [31:0] k, logic [31:0] v);
            cache_reply_t rep;
            int unsigned cap, ttl;
            int slot, free_slot;
            logic [31:0] deadline, age;
            cap = (cap_reg < 1) ? 1 : (cap_reg > 64) ? 64 : cap_reg;
            ttl = (ttl_reg < 1) ? 1 : (ttl_reg > tlc_pkg::TTL_MAX) ? tlc_pkg::TTL_MAX : ttl_reg;
            rep.read_value = 0;
            rep.status = tlc_pkg::ST_TICKED;
            case (act)
                tlc_pkg::ACT_GET:
                begin
                    slot = find_slot(k);
                    if (slot < 0)
                    begin
                        misses = sat_bump(misses, 1);
                        rep.status = tlc_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        age = now - ent_deadline[slot];
                        if (!age[31])
                        begin
                            drop(slot);
                            expires = sat_bump(expires, 1);
                            misses = sat_bump(misses, 1);
                            rep.status = tlc_pkg::ST_EXPIRED;
                        end
                        else
                        begin
                            promote(slot);
                            hits = sat_bump(hits, 1);
                            rep.read_value = ent_data[slot];
                            rep.status = tlc_pkg::ST_HIT;
                        end
                    end
                end
                tlc_pkg::ACT_PUT:
                begin
                    deadline = now + ttl;
                    slot = find_slot(k);
                    if (slot >= 0)
                    begin
                        ent_data[slot] = v;
                        ent_deadline[slot] = deadline;
                        promote(slot);
                        rep.status = tlc_pkg::ST_UPDATED;
                    end
                    else
                    begin
                        rep.status = tlc_pkg::ST_INSERTED;
                        if (occ >= cap)
                        begin
                            for (int i = 0; i < 64; i++)
                                if (ent_valid[i] && ent_rank[i] + 1 == occ)
                                begin
                                    drop(i);
                                    evicts = sat_bump(evicts, 1);
                                    rep.status = tlc_pkg::ST_EVICTED;
                                    break;
                                end
                        end
                        free_slot = -1;
                        for (int i = 0; i < 64; i++)
                            if (!ent_valid[i])
                            begin
                                free_slot = i;
                                break;
                            end
                        if (free_slot >= 0)
                        begin
                            for (int j = 0; j < 64; j++)
                                if (ent_valid[j])
                                    ent_rank[j]++;
                            ent_valid[free_slot] = 1;
                            ent_key[free_slot] = k;
                            ent_data[free_slot] = v;
                            ent_deadline[free_slot] = deadline;
                            ent_rank[free_slot] = 0;
                            occ++;
                        end
                    end
                end
                tlc_pkg::ACT_CLEAR:
                begin
                    invals = sat_bump(invals, occ);
                    foreach (ent_valid[i]) ent_valid[i] = 0;
                    occ = 0;
                    rep.status = tlc_pkg::ST_CLEARED;
                end
                default:
                begin
                    now = now + 1;
                    rep.status = tlc_pkg::ST_TICKED;
                end
            endcase
            rep.entry_count = occ[6:0];
            rep.hits = hits;
            rep.misses = misses;
            rep.expires = expires;
            rep.evicts = evicts;
            rep.invals = invals;
            replies_q.push_back(rep);
        endfunction

        function void check_result(cache_reply_t got);
            cache_reply_t exp_rep;
            if (replies_q.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, status %0d", $time, got.status);
                errors++;
                return;
            end
            exp_rep = replies_q.pop_front();
            if (got.status !== exp_rep.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp_rep.status, got.status);
                errors++;
            end
            if (got.read_value !== exp_rep.read_value)
            begin
                $display("%0t: read_value expected %h actual %h", $time,
                         exp_rep.read_value, got.read_value);
                errors++;
            end
            if (got.entry_count !== exp_rep.entry_count)
            begin
                $display("%0t: entry_count expected %0d actual %0d", $time,
                         exp_rep.entry_count, got.entry_count);
                errors++;
            end
            if (got.hits !== exp_rep.hits)
            begin
                $display("%0t: hit_count expected %0d actual %0d", $time, exp_rep.hits, got.hits);
                errors++;
            end
            if (got.misses !== exp_rep.misses)
            begin
                $display("%0t: miss_count expected %0d actual %0d", $time,
                         exp_rep.misses, got.misses);
                errors++;
            end
            if (got.expires !== exp_rep.expires)
            begin
                $display("%0t: expiration_count expected %0d actual %0d", $time,
                         exp_rep.expires, got.expires);
                errors++;
            end
            if (got.evicts !== exp_rep.evicts)
            begin
                $display("%0t: eviction_count expected %0d actual %0d", $time,
                         exp_rep.evicts, got.evicts);
                errors++;
            end
            if (got.invals !== exp_rep.invals)
            begin
                $display("%0t: invalidation_count expected %0d actual %0d", $time,
                         exp_rep.invals, got.invals);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic                       cfg_index;
    logic [tlc_pkg::TTL_W-1:0]  cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 action;
    logic [tlc_pkg::KEY_W-1:0]  lookup_key;
    logic [tlc_pkg::DATA_W-1:0] write_value;
    logic                       out_valid;
    logic                       out_stall;
    logic [2:0]                 status;
    logic [tlc_pkg::DATA_W-1:0] read_value;
    logic [6:0]                 entry_count;
    logic [tlc_pkg::CNT_W-1:0]  hit_count;
    logic [tlc_pkg::CNT_W-1:0]  miss_count;
    logic [tlc_pkg::CNT_W-1:0]  expiration_count;
    logic [tlc_pkg::CNT_W-1:0]  eviction_count;
    logic [tlc_pkg::CNT_W-1:0]  invalidation_count;

    ttl_lru_cache dut (.*);

    cache_scoreboard sb;
    bit              long_hold;
    bit              no_gaps;
    logic [31:0]     key_pool [96];

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receive side: random stall per transfer, one long hold on request.
    initial
    begin
        cache_reply_t got;
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                n = 400;
                long_hold = 0;
            end
            else
                n = no_gaps ? 0 : $urandom_range(0, 9);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got.status = tlc_pkg::status_t'(status);
            got.read_value = read_value;
            got.entry_count = entry_count;
            got.hits = hit_count;
            got.misses = miss_count;
            got.expires = expiration_count;
            got.evicts = eviction_count;
            got.invals = invalidation_count;
            sb.check_result(got);
        end
    end

    task automatic send_item(tlc_pkg::action_t act, logic [31:0] k, logic [31:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        lookup_key <= k;
        write_value <= v;
        do @(posedge clk); while (in_stall);
        sb.note_input(act, k, v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.replies_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Register writes happen only with the block drained.
    task automatic set_reg(tlc_pkg::reg_index_t idx, logic [tlc_pkg::TTL_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic random_phase(int count, int pool_size);
        int r;
        logic [31:0] k;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 9) == 0) ? $urandom
                                            : key_pool[$urandom_range(0, pool_size - 1)];
            if (i % 50 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            if (r < 42)
                send_item(tlc_pkg::ACT_GET, k, $urandom);
            else if (r < 82)
                send_item(tlc_pkg::ACT_PUT, k, $urandom);
            else if (r < 97)
                send_item(tlc_pkg::ACT_TICK, $urandom, $urandom);
            else
                send_item(tlc_pkg::ACT_CLEAR, $urandom, $urandom);
        end
        no_gaps = 0;
    endtask

    initial
    begin
        int unsigned caps [8] = '{64, 4, 1, 0, 127, 16, 8, 33};
        int unsigned ttls [8] = '{60, 3, 1, 0, 131071, 86400, 5, 2};
        sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = tlc_pkg::REG_CAPACITY;
        cfg_data = '0;
        in_valid = 1'b0;
        action = tlc_pkg::ACT_GET;
        lookup_key = '0;
        write_value = '0;
        long_hold = 0;
        no_gaps = 0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every action, update, eviction, expiry, shrink.
        send_item(tlc_pkg::ACT_GET, 32'h0, 32'h0);
        send_item(tlc_pkg::ACT_PUT, 32'h0, 32'h0);
        send_item(tlc_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(tlc_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(tlc_pkg::ACT_GET, 32'h0, 32'hFFFF_FFFF);
        send_item(tlc_pkg::ACT_PUT, 32'h0, 32'h1234_5678);
        send_item(tlc_pkg::ACT_GET, 32'h0, 32'h0);
        send_item(tlc_pkg::ACT_TICK, 32'h0, 32'h0);
        send_item(tlc_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_reg(tlc_pkg::REG_TTL, 17'd1);
        send_item(tlc_pkg::ACT_PUT, 32'h55, 32'hA5A5_A5A5);
        send_item(tlc_pkg::ACT_GET, 32'h55, 32'h0);
        send_item(tlc_pkg::ACT_TICK, 32'h0, 32'h0);
        send_item(tlc_pkg::ACT_GET, 32'h55, 32'h0);
        for (int i = 0; i < 5; i++)
            send_item(tlc_pkg::ACT_PUT, 32'h100 + i, 32'h200 + i);
        set_reg(tlc_pkg::REG_CAPACITY, 17'd2);
        send_item(tlc_pkg::ACT_PUT, 32'h300, 32'h1);
        send_item(tlc_pkg::ACT_PUT, 32'h301, 32'h2);
        set_reg(tlc_pkg::REG_CAPACITY, 17'd1);
        send_item(tlc_pkg::ACT_PUT, 32'h302, 32'h3);
        send_item(tlc_pkg::ACT_CLEAR, 32'h0, 32'h0);

        for (int p = 0; p < 8; p++)
        begin
            set_reg(tlc_pkg::REG_CAPACITY, 17'(caps[p]));
            set_reg(tlc_pkg::REG_TTL, 17'(ttls[p]));
            if (p == 1)
                long_hold = 1;
            random_phase(150, (p == 4) ? 96
                : 2 * ((caps[p] < 1) ? 1 : (caps[p] > 40 ? 40 : caps[p])) + 2);
            if (p == 2)
                drain();
        end

        drain();
        repeat (150) @(posedge clk);
        if (sb.errors == 0 && sb.replies_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
